### hw/rtl/fsbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed button controller package
// Shared types, request and event codes, register indexes and the duty helper.
// ----------------------------------------------------------------------------
package fsbc_pkg;

   localparam int PCT_W    = 7;
   localparam int THR_W    = 20;
   localparam int DUTY_W   = 13;
   localparam int CSR_IDX_W = 3;
   localparam int NUM_LEVELS = 4;

   localparam logic [PCT_W-1:0] PCT_MAX = 7'd100;

   typedef logic [PCT_W-1:0] pct_type;
   typedef logic [NUM_LEVELS-1:0][PCT_W-1:0] level_set_type;

   typedef enum logic [2:0] {
      REQ_OFF  = 3'd0,
      REQ_SET  = 3'd1,
      REQ_NEXT = 3'd2,
      REQ_STOP = 3'd3,
      REQ_TICK = 3'd4
   } req_code_type;

   localparam logic [1:0] EV_NONE    = 2'd0;
   localparam logic [1:0] EV_SHORT   = 2'd1;
   localparam logic [1:0] EV_LONG    = 2'd2;
   localparam logic [1:0] EV_IGNORED = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_ONLINE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LVL_OFF  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LVL_LOW  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LVL_MED  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LVL_HIGH = 3'd6;

   typedef struct packed {
      logic              online;
      logic [THR_W-1:0]  long_ticks;
      logic [THR_W-1:0]  debounce_ticks;
      level_set_type     levels;
   } cfg_type;

   // floor(x / 100) as (x * ceil(2^27 / 100)) >> 27, exact for x below 2^20
   localparam int          DUTY_SHIFT = 27;
   localparam logic [20:0] DUTY_RECIP = 21'd1342178;

   function automatic logic [DUTY_W-1:0] duty_of(input pct_type pct);
      logic [19:0] scaled;
      logic [40:0] prod;
      scaled = {pct, 13'd0} - 20'(pct);
      prod   = 41'(scaled) * 41'(DUTY_RECIP);
      return prod[DUTY_SHIFT+DUTY_W-1:DUTY_SHIFT];
   endfunction

   function automatic pct_type clamp_pct(input logic [7:0] value);
      return (value > 8'(PCT_MAX)) ? PCT_MAX : value[PCT_W-1:0];
   endfunction

endpackage

### hw/rtl/fsbc_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed button controller registers
// Write-only configuration registers with their reset values.
// ----------------------------------------------------------------------------
module fsbc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [fsbc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [fsbc_pkg::THR_W-1:0]          csr_wdata,
   output fsbc_pkg::cfg_type                   cfg
);

   fsbc_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.online         <= 1'b0;
         cfg_ff.long_ticks     <= 20'd2000;
         cfg_ff.debounce_ticks <= 20'd50;
         cfg_ff.levels[0]      <= 7'd0;
         cfg_ff.levels[1]      <= 7'd50;
         cfg_ff.levels[2]      <= 7'd75;
         cfg_ff.levels[3]      <= 7'd100;
      end else if (csr_we) begin
         unique case (csr_index)
            fsbc_pkg::CSR_ONLINE:   cfg_ff.online         <= csr_wdata[0];
            fsbc_pkg::CSR_LONG:     cfg_ff.long_ticks     <= csr_wdata;
            fsbc_pkg::CSR_DEBOUNCE: cfg_ff.debounce_ticks <= csr_wdata;
            fsbc_pkg::CSR_LVL_OFF:  cfg_ff.levels[0] <= csr_wdata[fsbc_pkg::PCT_W-1:0];
            fsbc_pkg::CSR_LVL_LOW:  cfg_ff.levels[1] <= csr_wdata[fsbc_pkg::PCT_W-1:0];
            fsbc_pkg::CSR_LVL_MED:  cfg_ff.levels[2] <= csr_wdata[fsbc_pkg::PCT_W-1:0];
            fsbc_pkg::CSR_LVL_HIGH: cfg_ff.levels[3] <= csr_wdata[fsbc_pkg::PCT_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

### hw/rtl/fsbc_nearest.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed button controller nearest level
// Finds the configured level closest to a percentage, lower index on ties.
// ----------------------------------------------------------------------------
module fsbc_nearest (
   input  fsbc_pkg::pct_type       speed,
   input  fsbc_pkg::level_set_type levels,
   output logic [1:0]              idx,
   output logic                    exact
);

   always_comb begin
      logic [fsbc_pkg::PCT_W-1:0] diff;
      logic [fsbc_pkg::PCT_W-1:0] best_diff;
      logic [1:0]                 best;
      logic                       hit;
      best      = 2'd0;
      best_diff = '0;
      hit       = 1'b0;
      for (int i = 0; i < fsbc_pkg::NUM_LEVELS; i++) begin
         diff = (speed >= levels[i]) ? speed - levels[i] : levels[i] - speed;
         if (i == 0 || diff < best_diff) begin
            best_diff = diff;
            best      = 2'(i);
         end
         if (levels[i] == speed) begin
            hit = 1'b1;
         end
      end
      idx   = best;
      exact = hit;
   end

endmodule

### hw/rtl/fsbc_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed button controller core
// Speed and button state, updated once per transfer from the input register.
// ----------------------------------------------------------------------------
module fsbc_core #(
   parameter int TIMER_BITS = 21
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [2:0]          req_type,
   input  logic [7:0]          percentage,
   input  logic                button_level,
   input  fsbc_pkg::cfg_type   cfg,
   output fsbc_pkg::pct_type   speed_next,
   output logic [1:0]          event_next
);

   localparam int CMP_W = (TIMER_BITS > fsbc_pkg::THR_W) ? TIMER_BITS : fsbc_pkg::THR_W;

   fsbc_pkg::pct_type     speed_ff, speed_in;
   logic                  down_ff, down_in;
   logic [TIMER_BITS-1:0] timer_ff, timer_in;
   logic                  fired_ff, fired_in;
   logic [1:0]            event_in;

   logic [1:0]            cur_idx;
   logic [1:0]            nxt_idx;
   fsbc_pkg::pct_type     next_pct;

   fsbc_nearest u_nearest (
      .speed  (speed_ff),
      .levels (cfg.levels),
      .idx    (cur_idx),
      .exact  ()
   );

   assign nxt_idx  = cur_idx + 2'd1;
   assign next_pct = fsbc_pkg::clamp_pct({1'b0, cfg.levels[nxt_idx]});

   always_comb begin
      logic [TIMER_BITS-1:0] cnt;
      logic                  fired;
      speed_in = speed_ff;
      down_in  = down_ff;
      timer_in = timer_ff;
      fired_in = fired_ff;
      event_in = fsbc_pkg::EV_NONE;
      cnt      = timer_ff;
      fired    = fired_ff;
      unique case (fsbc_pkg::req_code_type'(req_type))
         fsbc_pkg::REQ_OFF, fsbc_pkg::REQ_STOP: speed_in = '0;
         fsbc_pkg::REQ_SET:  speed_in = fsbc_pkg::clamp_pct(percentage);
         fsbc_pkg::REQ_NEXT: speed_in = next_pct;
         fsbc_pkg::REQ_TICK: begin
            if (!button_level) begin
               if (!down_ff) begin
                  cnt   = TIMER_BITS'(1);
                  fired = 1'b0;
               end else if (timer_ff != '1) begin
                  cnt = timer_ff + TIMER_BITS'(1);
               end
               down_in = 1'b1;
               if (CMP_W'(cnt) > CMP_W'(cfg.long_ticks) && !fired) begin
                  fired = 1'b1;
                  if (cfg.online) begin
                     event_in = fsbc_pkg::EV_IGNORED;
                  end else begin
                     speed_in = '0;
                     event_in = fsbc_pkg::EV_LONG;
                  end
               end
               timer_in = cnt;
               fired_in = fired;
            end else if (down_ff) begin
               down_in = 1'b0;
               if (!fired_ff && CMP_W'(timer_ff) > CMP_W'(cfg.debounce_ticks)
                   && CMP_W'(timer_ff) < CMP_W'(cfg.long_ticks)) begin
                  if (cfg.online) begin
                     event_in = fsbc_pkg::EV_IGNORED;
                  end else begin
                     speed_in = next_pct;
                     event_in = fsbc_pkg::EV_SHORT;
                  end
               end
               timer_in = '0;
               fired_in = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         down_ff  <= 1'b0;
         timer_ff <= '0;
         fired_ff <= 1'b0;
      end else if (step) begin
         speed_ff <= speed_in;
         down_ff  <= down_in;
         timer_ff <= timer_in;
         fired_ff <= fired_in;
      end
   end

   assign speed_next = speed_in;
   assign event_next = event_in;

endmodule

### hw/rtl/fsbc_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed button controller result decode
// Duty, power flag and level match from the registered result speed.
// ----------------------------------------------------------------------------
module fsbc_out (
   input  fsbc_pkg::pct_type                speed,
   input  fsbc_pkg::level_set_type          levels,
   output logic [fsbc_pkg::DUTY_W-1:0]      duty,
   output logic                             power_on,
   output logic [1:0]                       level_index,
   output logic                             level_exact
);

   fsbc_nearest u_nearest (
      .speed  (speed),
      .levels (levels),
      .idx    (level_index),
      .exact  (level_exact)
   );

   assign duty     = fsbc_pkg::duty_of(speed);
   assign power_on = (speed != '0);

endmodule

### hw/rtl/fan_speed_button_controller_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan speed button controller
// A request passes the input register, state update and result register in order.
// Throughput: one request per cycle while rsp_stall is low.
// Reset: synchronous; speed 0, button released, timer clear, registers at defaults.
// User must change registers only while no request is in flight (not enforced).
// ----------------------------------------------------------------------------
module fan_speed_button_controller_core #(
   parameter int TIMER_BITS = 21
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_type,
   input  logic [7:0]                         req_percentage,
   input  logic                               req_button_level,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [12:0]                        rsp_duty,
   output logic                               rsp_power_on,
   output logic [6:0]                         rsp_speed_percent,
   output logic [1:0]                         rsp_level_index,
   output logic                               rsp_level_exact,
   output logic [1:0]                         rsp_button_event,
   input  logic                               csr_we,
   input  logic [2:0]                         csr_index,
   input  logic [19:0]                        csr_wdata
);

   fsbc_pkg::cfg_type cfg;

   logic              s1_valid_ff, s1_valid_in;
   logic [2:0]        s1_type_ff;
   logic [7:0]        s1_pct_ff;
   logic              s1_button_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   fsbc_pkg::pct_type rsp_speed_ff;
   logic [1:0]        rsp_event_ff;

   logic              req_fire;
   logic              move;
   fsbc_pkg::pct_type speed_next;
   logic [1:0]        event_next;

   fsbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign move        = s1_valid_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall   = s1_valid_ff & ~move;
   assign req_fire    = req_valid & ~req_stall;
   assign s1_valid_in = req_fire | (s1_valid_ff & ~move);
   assign rsp_valid_in = move | (rsp_valid_ff & rsp_stall);

   fsbc_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (move),
      .req_type     (s1_type_ff),
      .percentage   (s1_pct_ff),
      .button_level (s1_button_ff),
      .cfg          (cfg),
      .speed_next   (speed_next),
      .event_next   (event_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_type_ff   <= req_type;
         s1_pct_ff    <= req_percentage;
         s1_button_ff <= req_button_level;
      end
      if (move) begin
         rsp_speed_ff <= speed_next;
         rsp_event_ff <= event_next;
      end
   end

   fsbc_out u_out (
      .speed       (rsp_speed_ff),
      .levels      (cfg.levels),
      .duty        (rsp_duty),
      .power_on    (rsp_power_on),
      .level_index (rsp_level_index),
      .level_exact (rsp_level_exact)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_speed_percent = rsp_speed_ff;
   assign rsp_button_event  = rsp_event_ff;

endmodule
